// File: rtl/timer_heap_scheduler_defines.svh
// Assertion macros shared by the timer heap scheduler RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef TIMER_HEAP_SCHEDULER_DEFINES_SVH
`define TIMER_HEAP_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define THS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
`define THS_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define THS_ASSERT_IMP(label, clk, rst_n, pre, post)
`define THS_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/ths_pkg.sv
// Package of the timer heap scheduler: types, sizes and codes.
// Used by every RTL module of the block; depends on nothing.
package ths_pkg;
	localparam int CAPACITY  = 16;
	localparam int ID_COUNT  = 64;
	localparam int TIME_BITS = 48;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int ID_W      = 6;
	localparam int IVL_W     = 32;
	localparam int LID_W     = $clog2(ID_COUNT);

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_FIRED  = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  timer_id;
		logic [47:0] when_time;
		logic [31:0] repeat_interval;
		logic [47:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  fired_id;
		logic        earliest_changed;
		logic [47:0] next_expire;
		logic        next_valid;
		logic        full_error;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [TIME_BITS-1:0] expiry;
		logic [IVL_W-1:0]     ivl;
	} slot_t;

	// Shared compare unit request: is a strictly below b.
	typedef struct packed {
		logic [TIME_BITS-1:0] a;
		logic [TIME_BITS-1:0] b;
	} cmp_req_t;
endpackage

// File: rtl/ths_cmp.sv
// Shared time comparator and saturating adder of the timer heap scheduler.
// Depends on ths_pkg.
module ths_cmp (
	input  ths_pkg::cmp_req_t                req,
	input  logic [ths_pkg::TIME_BITS-1:0]    now,
	input  logic [ths_pkg::IVL_W-1:0]        ivl,
	output logic                             less,
	output logic [ths_pkg::TIME_BITS-1:0]    resched
);
	logic [ths_pkg::TIME_BITS:0] sum;

	assign less = req.a < req.b;
	assign sum  = {1'b0, now} + {{(ths_pkg::TIME_BITS + 1 - ths_pkg::IVL_W){1'b0}}, ivl};
	// Reinsertion time saturates at the largest representable time.
	assign resched = sum[ths_pkg::TIME_BITS] ? {ths_pkg::TIME_BITS{1'b1}}
		: sum[ths_pkg::TIME_BITS-1:0];
endmodule

// File: rtl/timer_heap_scheduler.sv
// Channel  | ports                  | handshake
// command  | start, busy, cmd       | accepted when start && !busy
// result   | res_valid, res         | each item shown for one cycle, no stall
// An add climbs the new entry up level by level until it reaches the top or
// stops below a parent that is not later; a full add or a cancel reads the top.
// A tick checks the top and pops each expired entry, sifting the last entry down
// from the top after each pop; then it walks the popped entries once to fire them
// and once more to push back the periodic ones as adds, and reads the top.
// Each result shows up in the cycle after the state that makes it; the final one
// in the first cycle with busy low. Reset clears the count and live bits.
// Top level of the timer heap scheduler; depends on ths_pkg, ths_cmp and the
// assertion header.
`include "timer_heap_scheduler_defines.svh"
module timer_heap_scheduler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ths_pkg::cmd_t     cmd,
	output logic              res_valid,
	output ths_pkg::result_t  res
);
	localparam int IW = ths_pkg::IDX_W;
	localparam int CW = ths_pkg::CNT_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_ADD     = 4'd1;
	localparam logic [3:0] S_UP_RD   = 4'd2;
	localparam logic [3:0] S_UP_CMP  = 4'd3;
	localparam logic [3:0] S_TOPRD   = 4'd4;
	localparam logic [3:0] S_DONE    = 4'd5;
	localparam logic [3:0] S_T_TOP   = 4'd6;
	localparam logic [3:0] S_T_CHK   = 4'd7;
	localparam logic [3:0] S_T_LAST  = 4'd8;
	localparam logic [3:0] S_DN_LD   = 4'd9;
	localparam logic [3:0] S_DN_RD   = 4'd10;
	localparam logic [3:0] S_DN_R2   = 4'd11;
	localparam logic [3:0] S_DN_PICK = 4'd12;
	localparam logic [3:0] S_DN_CMP  = 4'd13;
	localparam logic [3:0] S_FIRE    = 4'd14;
	localparam logic [3:0] S_RE      = 4'd15;

	logic [3:0] state_q;
	ths_pkg::cmd_t cmd_q;
	logic [CW-1:0] count_q;
	logic [ths_pkg::ID_COUNT-1:0] live_q;

	// Heap slot memory, registered read.
	ths_pkg::slot_t heap_mem [ths_pkg::CAPACITY];
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic we;
	ths_pkg::slot_t wdata, rdata_q;

	// Entries popped by a tick, in pop order.
	ths_pkg::slot_t pop_buf [ths_pkg::CAPACITY];
	logic pop_we;
	logic [CW-1:0] pop_n_q, walk_q;

	logic [IW-1:0] idx_q, kid_q, parent;
	logic [IW:0] kl, kr;
	ths_pkg::slot_t cur_q, kid_slot_q;
	logic ec_q, ferr_q, re_q;
	logic heap_nonempty;
	logic res_fire;
	logic [1:0] done_kind;

	ths_pkg::cmp_req_t creq;
	logic less;
	logic [ths_pkg::TIME_BITS-1:0] resched;
	ths_pkg::slot_t walk_slot;
	logic walk_live;

	ths_cmp u_cmp (
		.req(creq), .now(cmd_q.now_time), .ivl(walk_slot.ivl),
		.less(less), .resched(resched)
	);

	assign walk_slot = pop_buf[walk_q[IW-1:0]];
	assign walk_live = live_q[walk_slot.id];
	assign busy = (state_q != S_IDLE);
	assign heap_nonempty = (count_q != '0);
	assign parent = (idx_q - IW'(1)) >> 1;
	assign kl = {idx_q, 1'b1};
	assign kr = kl + (IW+1)'(1);
	assign pop_we = (state_q == S_T_CHK) && heap_nonempty && less;
	assign res_fire = (state_q == S_DONE) ||
		((state_q == S_FIRE) && (walk_q != pop_n_q) && walk_live);

	always_ff @(posedge clk) begin
		if (we) heap_mem[waddr] <= wdata;
		rdata_q <= heap_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (pop_we) pop_buf[pop_n_q[IW-1:0]] <= rdata_q;
	end

	always_comb begin
		case (cmd_q.mode)
			ths_pkg::MODE_ADD:    done_kind = ths_pkg::KIND_ADD;
			ths_pkg::MODE_CANCEL: done_kind = ths_pkg::KIND_CANCEL;
			default:              done_kind = ths_pkg::KIND_DONE;
		endcase
	end

	always_comb begin
		creq = '0;
		case (state_q)
			S_ADD:     begin creq.a = cmd_q.when_time; creq.b = rdata_q.expiry; end
			S_UP_CMP:  begin creq.a = cur_q.expiry; creq.b = rdata_q.expiry; end
			S_T_CHK:   begin creq.a = rdata_q.expiry; creq.b = cmd_q.now_time; end
			S_DN_PICK: begin creq.a = rdata_q.expiry; creq.b = kid_slot_q.expiry; end
			S_DN_CMP:  begin creq.a = kid_slot_q.expiry; creq.b = cur_q.expiry; end
			default: ;
		endcase
	end

	// Idle and the top-read states read address zero.
	always_comb begin
		raddr = '0;
		we = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		case (state_q)
			S_UP_RD: begin
				if (idx_q == '0) we = 1'b1;
				else raddr = parent;
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (less) wdata = rdata_q;
			end
			S_T_LAST: raddr = count_q[IW-1:0];
			S_DN_RD: begin
				if (kl >= (IW+1)'(count_q)) we = 1'b1;
				else raddr = kl[IW-1:0];
			end
			S_DN_R2: raddr = kr[IW-1:0];
			S_DN_CMP: begin
				we = 1'b1;
				if (less) wdata = kid_slot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= '0;
			count_q    <= '0;
			live_q     <= '0;
			pop_n_q    <= '0;
			walk_q     <= '0;
			idx_q      <= '0;
			kid_q      <= '0;
			cur_q      <= '0;
			kid_slot_q <= '0;
			ec_q       <= 1'b0;
			ferr_q     <= 1'b0;
			re_q       <= 1'b0;
			res_valid  <= 1'b0;
			res        <= '0;
		end else begin
			res_valid <= res_fire;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						ec_q <= 1'b0;
						ferr_q <= (cmd.mode == ths_pkg::MODE_ADD) &&
							(count_q == CW'(ths_pkg::CAPACITY));
						re_q <= 1'b0;
						pop_n_q <= '0;
						case (cmd.mode)
							ths_pkg::MODE_ADD: begin
								if (count_q == CW'(ths_pkg::CAPACITY)) state_q <= S_TOPRD;
								else state_q <= S_ADD;
							end
							ths_pkg::MODE_CANCEL: begin
								live_q[cmd.timer_id] <= 1'b0;
								state_q <= S_TOPRD;
							end
							ths_pkg::MODE_TICK: state_q <= S_T_TOP;
							default: ;
						endcase
					end
				end
				S_ADD: begin
					// rdata_q holds the old top, read while idle.
					ec_q <= !heap_nonempty || less;
					live_q[cmd_q.timer_id] <= 1'b1;
					cur_q <= '{id: cmd_q.timer_id, expiry: cmd_q.when_time,
						ivl: cmd_q.repeat_interval};
					idx_q <= count_q[IW-1:0];
					count_q <= count_q + 1'b1;
					state_q <= S_UP_RD;
				end
				S_UP_RD: begin
					if (idx_q == '0) state_q <= re_q ? S_RE : S_TOPRD;
					else state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					// Parent strictly greater than the moving entry: swap up.
					if (less) begin
						idx_q <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= re_q ? S_RE : S_TOPRD;
					end
				end
				S_TOPRD: state_q <= S_DONE;
				S_DONE: begin
					res <= '{kind: done_kind, fired_id: '0, earliest_changed: ec_q,
						next_expire: heap_nonempty ? rdata_q.expiry : '0,
						next_valid: heap_nonempty, full_error: ferr_q, last: 1'b1};
					state_q <= S_IDLE;
				end
				S_T_TOP: state_q <= S_T_CHK;
				S_T_CHK: begin
					if (pop_we) begin
						pop_n_q <= pop_n_q + 1'b1;
						count_q <= count_q - 1'b1;
						state_q <= (count_q == CW'(1)) ? S_T_TOP : S_T_LAST;
					end else begin
						walk_q <= '0;
						state_q <= S_FIRE;
					end
				end
				S_T_LAST: state_q <= S_DN_LD;
				S_DN_LD: begin
					// The last entry moves to the top and sifts down from there.
					cur_q <= rdata_q;
					idx_q <= '0;
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (kl >= (IW+1)'(count_q)) state_q <= S_T_TOP;
					else state_q <= S_DN_R2;
				end
				S_DN_R2: begin
					kid_slot_q <= rdata_q;
					kid_q <= kl[IW-1:0];
					if (kr < (IW+1)'(count_q)) state_q <= S_DN_PICK;
					else state_q <= S_DN_CMP;
				end
				S_DN_PICK: begin
					// The right child takes over only when strictly smaller.
					if (less) begin
						kid_slot_q <= rdata_q;
						kid_q <= kr[IW-1:0];
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (less) begin
						idx_q <= kid_q;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_T_TOP;
					end
				end
				S_FIRE: begin
					if (walk_q == pop_n_q) begin
						walk_q <= '0;
						state_q <= S_RE;
					end else begin
						walk_q <= walk_q + 1'b1;
						if (walk_live) begin
							res <= '{kind: ths_pkg::KIND_FIRED, fired_id: walk_slot.id,
								earliest_changed: 1'b0, next_expire: '0, next_valid: 1'b0,
								full_error: 1'b0, last: 1'b0};
						end
					end
				end
				S_RE: begin
					if (walk_q == pop_n_q) state_q <= S_TOPRD;
					else begin
						walk_q <= walk_q + 1'b1;
						if (walk_live) begin
							if (walk_slot.ivl != '0) begin
								if (count_q < CW'(ths_pkg::CAPACITY)) begin
									cur_q <= '{id: walk_slot.id, expiry: resched,
										ivl: walk_slot.ivl};
									idx_q <= count_q[IW-1:0];
									count_q <= count_q + 1'b1;
									re_q <= 1'b1;
									state_q <= S_UP_RD;
								end
							end else live_q[walk_slot.id] <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`THS_ASSERT_IMP(a_res_idle, clk, arst_n, res_valid && res.last, state_q == S_IDLE)
	`THS_ASSERT_IMP(a_count, clk, arst_n, 1'b1, count_q <= CW'(ths_pkg::CAPACITY))
	`THS_ASSERT_NXT(a_busy, clk, arst_n, start && !busy && cmd.mode != ths_pkg::MODE_UNUSED, busy)
	`THS_ASSERT_IMP(a_fired_open, clk, arst_n, res_valid && res.kind == ths_pkg::KIND_FIRED, !res.last)
endmodule
